// File: rtl/nur_pkg.sv
// Shared types, codes and a helper function of the NMEA and UBX frame receiver.
package nur_pkg;

  typedef enum logic [1:0] {
    FUNC_RX      = 2'd0,
    FUNC_READ    = 2'd1,
    FUNC_RELEASE = 2'd2,
    FUNC_NOP     = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    RES_COMPLETE = 2'd0,
    RES_READ     = 2'd1,
    RES_RELEASE  = 2'd2,
    RES_UNUSED   = 2'd3
  } result_kind_t;

  typedef enum logic [1:0] {
    OP_RX      = 2'd0,
    OP_READ    = 2'd1,
    OP_RELEASE = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] rx_byte;
    logic       read_field_table;
    logic [6:0] read_index;
  } item_t;

  typedef struct packed {
    logic       ok;
    logic [4:0] last;
    logic [7:0] len;
    logic       frame_type;
  } slot_info_t;

  localparam logic [7:0] UBX_SYNC1  = 8'hB5;
  localparam logic [7:0] UBX_SYNC2  = 8'h62;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) v = c[3:0];
    else if (c >= 8'h41 && c <= 8'h46) v = 4'(c[3:0] + 4'd9);
    return v;
  endfunction

endpackage

// File: rtl/nur_front.sv
// Front end: accepts input transfers, decodes the function and queues the work.
module nur_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [15:0]   s_tdata,
  input  logic [2:0]    s_tuser,
  output logic          q_valid,
  output nur_pkg::item_t q_item,
  input  logic          q_pop
);
  import nur_pkg::*;

  item_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  item_t      in_item;

  always_comb begin
    in_item.rx_byte          = s_tdata[7:0];
    in_item.read_index       = s_tdata[14:8];
    in_item.read_field_table = s_tuser[2];
    unique case (func_t'(s_tuser[1:0]))
      FUNC_RX:      in_item.op = OP_RX;
      FUNC_READ:    in_item.op = OP_READ;
      FUNC_RELEASE: in_item.op = OP_RELEASE;
      default:      in_item.op = OP_NONE;
    endcase
  end

  assign s_tready = (count != 2'd2);
  assign push     = s_tvalid && s_tready && (in_item.op != OP_NONE);
  assign pop      = q_pop && q_valid;
  assign q_valid  = (count != 2'd0);
  assign q_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= 2'(count + {1'b0, push} - {1'b0, pop});
    end
  end

endmodule

// File: rtl/nur_back.sv
// Back end: frame parser, frame ring with its stores, and the result register.
module nur_back #(
  parameter int RING_SLOTS      = 4,
  parameter int NMEA_MAX_CHARS  = 84,
  parameter int NMEA_MAX_FIELDS = 32,
  parameter int UBX_MAX_BYTES   = 128
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  nur_pkg::item_t q_item,
  output logic           q_pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [31:0]    m_tdata,
  output logic [1:0]     m_tuser
);
  import nur_pkg::*;

  localparam int SLOT_BYTES = (NMEA_MAX_CHARS > UBX_MAX_BYTES) ? NMEA_MAX_CHARS : UBX_MAX_BYTES;
  localparam int CNT_MAX    = (SLOT_BYTES > NMEA_MAX_FIELDS) ? SLOT_BYTES : NMEA_MAX_FIELDS;
  localparam int SW   = $clog2(RING_SLOTS);
  localparam int CW   = $clog2(CNT_MAX + 1);
  localparam int PW   = $clog2(NMEA_MAX_CHARS + 1);
  localparam int BAW  = $clog2(RING_SLOTS * SLOT_BYTES);
  localparam int FAW  = $clog2(RING_SLOTS * NMEA_MAX_FIELDS);
  localparam int BODY_DEPTH  = RING_SLOTS * SLOT_BYTES;
  localparam int FIELD_DEPTH = RING_SLOTS * NMEA_MAX_FIELDS;

  typedef enum logic [13:0] {
    PS_START  = 14'b00000000000001,
    PS_NTEXT  = 14'b00000000000010,
    PS_NHEXH  = 14'b00000000000100,
    PS_NHEXL  = 14'b00000000001000,
    PS_NCR    = 14'b00000000010000,
    PS_NLF    = 14'b00000000100000,
    PS_USYNC2 = 14'b00000001000000,
    PS_UCLASS = 14'b00000010000000,
    PS_UID    = 14'b00000100000000,
    PS_ULENL  = 14'b00001000000000,
    PS_ULENH  = 14'b00010000000000,
    PS_UPAY   = 14'b00100000000000,
    PS_UCKA   = 14'b01000000000000,
    PS_UCKB   = 14'b10000000000000
  } pstate_t;

  pstate_t         parse_state, parse_state_next;
  logic [15:0]     ubx_remaining, ubx_remaining_next;
  logic [PW-1:0]   nmea_position, nmea_position_next;
  logic [CW-1:0]   byte_count, byte_count_next;
  logic [7:0]      running_xor, running_xor_next;
  logic [7:0]      expected_xor, expected_xor_next;
  logic [SW-1:0]   write_slot, write_slot_next;
  logic [SW-1:0]   read_slot, read_slot_next;
  slot_info_t      slot_info [RING_SLOTS];

  logic [7:0]      body_store  [BODY_DEPTH];
  logic [7:0]      field_store [FIELD_DEPTH];

  logic            fire;
  logic            bw_en, fw_en, br_en, fr_en;
  logic [BAW-1:0]  bw_addr, br_addr;
  logic [FAW-1:0]  fw_addr, fr_addr;
  logic [7:0]      bw_data, fw_data;
  logic [7:0]      body_q, field_q;
  logic            use_body, use_field;

  logic            info_we;
  slot_info_t      info_new;
  logic            res_en;
  result_kind_t    res_kind;
  slot_info_t      res_info;
  logic [SW-1:0]   res_slot;
  logic            res_lost, res_empty;

  logic            done;
  logic            c_type, c_ok;
  logic [CW-1:0]   c_len;
  logic [CW-1:0]   c_last;
  logic [SW-1:0]   ws_inc, rs_inc;
  logic [7:0]      b;
  logic [CW-1:0]   cnt_inc;
  logic [PW-1:0]   pos_inc;
  logic            ubx_ok;
  slot_info_t      rinfo;

  result_kind_t    o_kind;
  slot_info_t      o_info;
  logic [SW+1:0]   o_slot_w;
  logic            o_lost, o_empty;

  assign fire  = q_valid && (!m_tvalid || m_tready);
  assign q_pop = fire;
  assign b     = q_item.rx_byte;
  assign ws_inc = (write_slot == SW'(RING_SLOTS - 1)) ? '0 : SW'(write_slot + 1'b1);
  assign rs_inc = (read_slot == SW'(RING_SLOTS - 1)) ? '0 : SW'(read_slot + 1'b1);
  assign cnt_inc = CW'(byte_count + 1'b1);
  assign pos_inc = PW'(nmea_position + 1'b1);
  assign ubx_ok  = (byte_count < CW'(UBX_MAX_BYTES));
  assign rinfo   = slot_info[read_slot];

  always_comb begin
    parse_state_next   = parse_state;
    ubx_remaining_next = ubx_remaining;
    nmea_position_next = nmea_position;
    byte_count_next    = byte_count;
    running_xor_next   = running_xor;
    expected_xor_next  = expected_xor;
    write_slot_next    = write_slot;
    read_slot_next     = read_slot;
    bw_en = 1'b0; bw_addr = '0; bw_data = b;
    fw_en = 1'b0; fw_addr = '0; fw_data = '0;
    br_en = 1'b0; br_addr = '0;
    fr_en = 1'b0; fr_addr = '0;
    done = 1'b0; c_type = 1'b0; c_ok = 1'b0; c_len = '0; c_last = '0;
    info_we = 1'b0; info_new = '0;
    res_en = 1'b0; res_kind = RES_COMPLETE; res_info = '0; res_slot = '0;
    res_lost = 1'b0; res_empty = 1'b0;

    unique case (q_item.op)
      OP_RX: begin
        unique case (parse_state)
          PS_START: begin
            if (b == UBX_SYNC1) begin
              bw_en = 1'b1;
              bw_addr = BAW'(write_slot * SLOT_BYTES);
              byte_count_next = CW'(1);
              parse_state_next = PS_USYNC2;
            end else if (b == CH_DOLLAR) begin
              byte_count_next = '0;
              running_xor_next = '0;
              nmea_position_next = '0;
              fw_en = 1'b1;
              fw_addr = FAW'(write_slot * NMEA_MAX_FIELDS);
              fw_data = '0;
              parse_state_next = PS_NTEXT;
            end
          end
          PS_NTEXT: begin
            if (nmea_position >= PW'(NMEA_MAX_CHARS)) begin
              parse_state_next = PS_START;
            end else if (b == CH_COMMA) begin
              bw_en = 1'b1;
              bw_addr = BAW'(write_slot * SLOT_BYTES + nmea_position);
              bw_data = '0;
              nmea_position_next = pos_inc;
              byte_count_next = cnt_inc;
              if (cnt_inc >= CW'(NMEA_MAX_FIELDS)) begin
                parse_state_next = PS_START;
              end else begin
                fw_en = 1'b1;
                fw_addr = FAW'(write_slot * NMEA_MAX_FIELDS + cnt_inc);
                fw_data = 8'(pos_inc);
                running_xor_next = running_xor ^ b;
              end
            end else if (b == CH_STAR) begin
              parse_state_next = PS_NHEXH;
            end else begin
              bw_en = 1'b1;
              bw_addr = BAW'(write_slot * SLOT_BYTES + nmea_position);
              nmea_position_next = pos_inc;
              running_xor_next = running_xor ^ b;
            end
          end
          PS_NHEXH: begin
            expected_xor_next = {hex_value(b), 4'd0};
            parse_state_next = PS_NHEXL;
          end
          PS_NHEXL: begin
            expected_xor_next = {expected_xor[7:4], hex_value(b)};
            parse_state_next = PS_NCR;
          end
          PS_NCR: begin
            parse_state_next = (b == CH_CR) ? PS_NLF : PS_START;
          end
          PS_NLF: begin
            parse_state_next = PS_START;
            if (b == CH_LF) begin
              done = 1'b1;
              c_type = 1'b1;
              c_len = CW'(nmea_position);
              c_last = byte_count;
              c_ok = (running_xor == expected_xor);
            end
          end
          default: begin
            if (parse_state == PS_USYNC2 && b != UBX_SYNC2) begin
              parse_state_next = PS_START;
            end else if (!ubx_ok) begin
              parse_state_next = PS_START;
            end else begin
              bw_en = 1'b1;
              bw_addr = BAW'(write_slot * SLOT_BYTES + byte_count);
              byte_count_next = cnt_inc;
              priority case (parse_state)
                PS_USYNC2: parse_state_next = PS_UCLASS;
                PS_UCLASS: parse_state_next = PS_UID;
                PS_UID:    parse_state_next = PS_ULENL;
                PS_ULENL: begin
                  ubx_remaining_next = {8'd0, b};
                  parse_state_next = PS_ULENH;
                end
                PS_ULENH: begin
                  ubx_remaining_next = {b, ubx_remaining[7:0]};
                  parse_state_next = ({b, ubx_remaining[7:0]} == 16'd0) ? PS_UCKA : PS_UPAY;
                end
                PS_UPAY: begin
                  ubx_remaining_next = 16'(ubx_remaining - 1'b1);
                  if (ubx_remaining == 16'd1) parse_state_next = PS_UCKA;
                end
                PS_UCKA: parse_state_next = PS_UCKB;
                default: begin
                  parse_state_next = PS_START;
                  done = 1'b1;
                  c_len = cnt_inc;
                end
              endcase
            end
          end
        endcase
        if (done) begin
          res_en = 1'b1;
          res_kind = RES_COMPLETE;
          res_slot = write_slot;
          info_new.frame_type = c_type;
          info_new.len  = (c_len > CW'(255)) ? 8'd255 : 8'(c_len);
          info_new.last = (c_last > CW'(31)) ? 5'd31 : 5'(c_last);
          info_new.ok   = c_ok;
          res_info = info_new;
          if (ws_inc != read_slot) begin
            info_we = 1'b1;
            write_slot_next = ws_inc;
          end else begin
            res_lost = 1'b1;
          end
        end
      end
      OP_READ, OP_RELEASE: begin
        res_en = 1'b1;
        res_kind = (q_item.op == OP_READ) ? RES_READ : RES_RELEASE;
        if (read_slot == write_slot) begin
          res_empty = 1'b1;
        end else begin
          res_slot = read_slot;
          res_info = rinfo;
          if (q_item.op == OP_READ) begin
            if (!q_item.read_field_table) begin
              if ({1'b0, q_item.read_index} < rinfo.len &&
                  q_item.read_index < 7'(SLOT_BYTES > 127 ? 127 : SLOT_BYTES) ||
                  ({1'b0, q_item.read_index} < rinfo.len && SLOT_BYTES > 127)) begin
                br_en = 1'b1;
                br_addr = BAW'(read_slot * SLOT_BYTES + q_item.read_index);
              end
            end else begin
              if (rinfo.frame_type && {1'b0, q_item.read_index} <= {3'd0, rinfo.last} &&
                  {1'b0, q_item.read_index} < 8'(NMEA_MAX_FIELDS)) begin
                fr_en = 1'b1;
                fr_addr = FAW'(read_slot * NMEA_MAX_FIELDS + q_item.read_index);
              end
            end
          end else begin
            read_slot_next = rs_inc;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fire && bw_en) body_store[bw_addr] <= bw_data;
    if (fire && br_en) body_q <= body_store[br_addr];
  end

  always_ff @(posedge clk) begin
    if (fire && fw_en) field_store[fw_addr] <= fw_data;
    if (fire && fr_en) field_q <= field_store[fr_addr];
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      o_kind  <= res_kind;
      o_info  <= res_info;
      o_slot_w <= {2'b00, res_slot};
      o_lost  <= res_lost;
      o_empty <= res_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state   <= PS_START;
      ubx_remaining <= '0;
      nmea_position <= '0;
      byte_count    <= '0;
      running_xor   <= '0;
      expected_xor  <= '0;
      write_slot    <= '0;
      read_slot     <= '0;
      m_tvalid      <= 1'b0;
      use_body      <= 1'b0;
      use_field     <= 1'b0;
      for (int i = 0; i < RING_SLOTS; i++) slot_info[i] <= '0;
    end else begin
      if (fire) begin
        parse_state   <= parse_state_next;
        ubx_remaining <= ubx_remaining_next;
        nmea_position <= nmea_position_next;
        byte_count    <= byte_count_next;
        running_xor   <= running_xor_next;
        expected_xor  <= expected_xor_next;
        write_slot    <= write_slot_next;
        read_slot     <= read_slot_next;
        m_tvalid      <= res_en;
        use_body      <= br_en;
        use_field     <= fr_en;
        if (info_we) slot_info[write_slot] <= info_new;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_comb begin
    m_tuser = o_kind;
    m_tdata = '0;
    m_tdata[0]     = o_info.frame_type;
    m_tdata[2:1]   = o_slot_w[1:0];
    m_tdata[10:3]  = o_info.len;
    m_tdata[15:11] = o_info.last;
    m_tdata[16]    = o_info.ok;
    m_tdata[17]    = o_lost;
    m_tdata[25:18] = use_body ? body_q : (use_field ? field_q : 8'd0);
    m_tdata[26]    = o_empty;
  end

endmodule

// File: rtl/nmea_ubx_frame_receiver_unit.sv
// Top level of the NMEA and UBX frame receiver: front queue and parser back end.
//
//  Channel | Direction | Holds
//  s_*     | in        | tuser: func[1:0], read_field_table[2]; tdata: rx_byte, read_index
//  m_*     | out       | tuser: result_kind; tdata: frame fields, read_data, ring_empty
//
// One item is taken per cycle while the output is not stalled; the parser and ring update once per item.
// A result is valid from the clock edge after its item leaves the front queue, when the output is free.
// Reads of the frame stores are registered memory reads, captured at the same edge as the result.
// Reset is synchronous; the frame stores are not cleared and need no pass.
// A stalled output holds the back end; the front queue keeps accepting until full.
module nmea_ubx_frame_receiver_unit #(
  parameter int RING_SLOTS      = 4,
  parameter int NMEA_MAX_CHARS  = 84,
  parameter int NMEA_MAX_FIELDS = 32,
  parameter int UBX_MAX_BYTES   = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // rx_byte[7:0], read_index[14:8], zero[15]
  input  logic [2:0]  s_tuser,   // func[1:0], read_field_table[2]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // frame_type[0], slot[2:1], frame_length[10:3],
                                 // last_field_index[15:11], checksum_ok[16],
                                 // frame_lost_full[17], read_data[25:18], ring_empty[26]
  output logic [1:0]  m_tuser    // result_kind[1:0]
);
  import nur_pkg::*;

  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  nur_front u_front (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  nur_back #(
    .RING_SLOTS(RING_SLOTS), .NMEA_MAX_CHARS(NMEA_MAX_CHARS),
    .NMEA_MAX_FIELDS(NMEA_MAX_FIELDS), .UBX_MAX_BYTES(UBX_MAX_BYTES)
  ) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

endmodule

// File: rtl/nur_checker.sv
// Port-level checks of the frame receiver, bound to the top level.
module nur_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [1:0]  m_tuser
);
  import nur_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("Result valid right after reset.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("Stalled result changed.");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser != RES_UNUSED)
    else $error("Unknown result kind.");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[26] |-> m_tuser != RES_COMPLETE && m_tdata[25:0] == 26'd0)
    else $error("Empty-ring result carries data.");

  a_lost: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[17] |-> m_tuser == RES_COMPLETE && m_tdata[25:18] == 8'd0)
    else $error("Lost flag on a result that is not a completion.");

endmodule

bind nmea_ubx_frame_receiver_unit nur_checker u_nur_checker (.*);
